// ===== rtl/gvc_pkg.sv =====
// ============================================================================
// gvc_pkg: shared types and constants for the greedy vertex cover block
// Store sizes, derived widths, memory words, request groups and states.
// ============================================================================
package gvc_pkg;

    // sizes of the stores and of one bitmap chunk
    localparam int NODES      = 256;
    localparam int MAX_EDGES  = 256;
    localparam int CHUNK_BITS = 32;

    // transaction field widths
    localparam int END_W  = 8;
    localparam int CIDX_W = 3;
    localparam int BITS_W = 32;
    localparam int RCNT_W = 9;

    // derived widths
    localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int EDGE_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECNT_W = $clog2(MAX_EDGES + 1);
    localparam int NCNT_W = $clog2(NODES + 1);
    localparam int DEG_W  = 10;
    localparam int CHUNKS = (NODES + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int CHK_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int CB_W   = $clog2(CHUNK_BITS);
    localparam int SPAN_W = $clog2(CHUNKS * CHUNK_BITS + 1);

    localparam logic [DEG_W-1:0] DEG_MAX = '1;

    // node store word
    typedef struct packed {
        logic             removed;
        logic [DEG_W-1:0] degree;
    } t_node_word;

    // edge store word
    typedef struct packed {
        logic              covered;
        logic [NODE_W-1:0] first;
        logic [NODE_W-1:0] second;
    } t_edge_word;

    // node store access: one write and one read address per cycle
    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        t_node_word        wdata;
        logic [NODE_W-1:0] raddr;
    } t_node_req;

    // edge store access
    typedef struct packed {
        logic              we;
        logic [EDGE_W-1:0] waddr;
        t_edge_word        wdata;
        logic [EDGE_W-1:0] raddr;
    } t_edge_req;

    // one bitmap chunk for the result channel
    typedef struct packed {
        logic [CIDX_W-1:0] index;
        logic [BITS_W-1:0] bits;
        logic [RCNT_W-1:0] count;
        logic              dropped;
        logic              last;
    } t_chunk;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RDA,
        S_WRA,
        S_RDB,
        S_WRB,
        S_START,
        S_SCAN,
        S_PICK,
        S_EISSUE,
        S_ECHK,
        S_DEC,
        S_OUT_RD,
        S_SHOW
    } t_state;

endpackage

// ===== rtl/gvc_node_mem.sv =====
// ============================================================================
// gvc_node_mem: node store
// Degree and removed flag per node, one write and one registered read a cycle.
// ============================================================================
module gvc_node_mem (
    input  logic               i_clk,
    input  gvc_pkg::t_node_req i_req,
    output gvc_pkg::t_node_word o_rdata
);

    gvc_pkg::t_node_word r_mem [gvc_pkg::NODES];
    gvc_pkg::t_node_word r_rdata;

    // write port and registered read port, read returns the old word
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gvc_edge_mem.sv =====
// ============================================================================
// gvc_edge_mem: edge store
// Endpoints and covered flag per stored edge, registered read.
// ============================================================================
module gvc_edge_mem (
    input  logic                i_clk,
    input  gvc_pkg::t_edge_req  i_req,
    output gvc_pkg::t_edge_word o_rdata
);

    gvc_pkg::t_edge_word r_mem [gvc_pkg::MAX_EDGES];
    gvc_pkg::t_edge_word r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gvc_ctrl.sv =====
// ============================================================================
// gvc_ctrl: sequencer and shared compare unit
// Loads edges and degrees, runs the max-degree scan and edge sweeps, and
// gathers the cover bitmap chunk by chunk while clearing the node store.
// ============================================================================
module gvc_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [gvc_pkg::END_W-1:0]        i_end_a,
    input  logic [gvc_pkg::END_W-1:0]        i_end_b,
    input  logic                             i_edge_valid,
    input  logic                             i_set_last,
    output gvc_pkg::t_node_req               o_node_req,
    input  gvc_pkg::t_node_word              i_node_rd,
    output gvc_pkg::t_edge_req               o_edge_req,
    input  gvc_pkg::t_edge_word              i_edge_rd,
    output logic                             o_load,
    output gvc_pkg::t_chunk                  o_chunk,
    input  logic                             i_taken
);

    gvc_pkg::t_state                 r_state, n_state;
    logic [gvc_pkg::NODE_W-1:0]      r_a, n_a;
    logic [gvc_pkg::NODE_W-1:0]      r_b, n_b;
    logic                            r_last, n_last;
    logic [gvc_pkg::ECNT_W-1:0]      r_total, n_total;
    logic [gvc_pkg::ECNT_W-1:0]      r_uncov, n_uncov;
    logic                            r_over, n_over;
    logic [gvc_pkg::NCNT_W-1:0]      r_count, n_count;
    logic [gvc_pkg::NODE_W:0]        r_idx, n_idx;
    logic [gvc_pkg::DEG_W-1:0]       r_best, n_best;
    logic [gvc_pkg::NODE_W-1:0]      r_pick, n_pick;
    logic                            r_found, n_found;
    logic [gvc_pkg::ECNT_W-1:0]      r_e, n_e;
    logic [gvc_pkg::NODE_W-1:0]      r_other, n_other;
    logic [gvc_pkg::CHK_W-1:0]       r_chunk, n_chunk;
    logic [gvc_pkg::CB_W:0]          r_bit, n_bit;
    logic                            r_rd_ok, n_rd_ok;
    logic [gvc_pkg::CHUNK_BITS-1:0]  r_bits, n_bits;

    logic                            in_range;
    logic                            hit;
    logic                            e_done;
    logic                            chunk_last;
    logic [gvc_pkg::SPAN_W-1:0]      span;
    logic                            span_ok;

    // state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gvc_pkg::S_CLEAR;
            r_idx   <= '0;
            r_total <= '0;
            r_uncov <= '0;
            r_over  <= 1'b0;
            r_count <= '0;
            r_found <= 1'b0;
            r_e     <= '0;
            r_chunk <= '0;
            r_bit   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_total <= n_total;
            r_uncov <= n_uncov;
            r_over  <= n_over;
            r_count <= n_count;
            r_found <= n_found;
            r_e     <= n_e;
            r_chunk <= n_chunk;
            r_bit   <= n_bit;
            r_rd_ok <= n_rd_ok;
        end
        r_a     <= n_a;
        r_b     <= n_b;
        r_last  <= n_last;
        r_best  <= n_best;
        r_pick  <= n_pick;
        r_other <= n_other;
        r_bits  <= n_bits;
    end

    // shared decode terms
    assign in_range = (32'(i_end_a) < gvc_pkg::NODES) && (32'(i_end_b) < gvc_pkg::NODES);
    assign hit = !i_edge_rd.covered &&
                 ((i_edge_rd.first == r_pick) || (i_edge_rd.second == r_pick));
    assign e_done = ((r_e + gvc_pkg::ECNT_W'(1)) == r_total);
    assign chunk_last = (r_chunk == gvc_pkg::CHK_W'(gvc_pkg::CHUNKS - 1));
    assign span = gvc_pkg::SPAN_W'(r_chunk) * gvc_pkg::SPAN_W'(gvc_pkg::CHUNK_BITS)
                + gvc_pkg::SPAN_W'(r_bit);
    assign span_ok = (r_bit < (gvc_pkg::CB_W + 1)'(gvc_pkg::CHUNK_BITS)) &&
                     (32'(span) < gvc_pkg::NODES);

    assign o_stall = (r_state != gvc_pkg::S_IDLE);

    // next state, memory requests and chunk hand-off
    always_comb begin
        n_state    = r_state;
        n_a        = r_a;
        n_b        = r_b;
        n_last     = r_last;
        n_total    = r_total;
        n_uncov    = r_uncov;
        n_over     = r_over;
        n_count    = r_count;
        n_idx      = r_idx;
        n_best     = r_best;
        n_pick     = r_pick;
        n_found    = r_found;
        n_e        = r_e;
        n_other    = r_other;
        n_chunk    = r_chunk;
        n_bit      = r_bit;
        n_rd_ok    = r_rd_ok;
        n_bits     = r_bits;
        o_node_req = '0;
        o_edge_req = '0;
        o_load     = 1'b0;

        o_chunk.index   = gvc_pkg::CIDX_W'(r_chunk);
        o_chunk.bits    = '0;
        o_chunk.count   = gvc_pkg::RCNT_W'(r_count);
        o_chunk.dropped = r_over;
        o_chunk.last    = chunk_last;

        unique case (r_state)
            // sweep zeros through the node store after reset
            gvc_pkg::S_CLEAR: begin
                o_node_req.we    = 1'b1;
                o_node_req.waddr = r_idx[gvc_pkg::NODE_W-1:0];
                n_idx            = r_idx + 1'b1;
                if (r_idx == (gvc_pkg::NODE_W + 1)'(gvc_pkg::NODES - 1)) begin
                    n_idx   = '0;
                    n_state = gvc_pkg::S_IDLE;
                end
            end

            // take one input transaction
            gvc_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_a    = gvc_pkg::NODE_W'(i_end_a);
                    n_b    = gvc_pkg::NODE_W'(i_end_b);
                    n_last = i_set_last;
                    n_state = i_set_last ? gvc_pkg::S_START : gvc_pkg::S_IDLE;
                    if (i_edge_valid && in_range) begin
                        if (r_total < gvc_pkg::ECNT_W'(gvc_pkg::MAX_EDGES)) begin
                            o_edge_req.we            = 1'b1;
                            o_edge_req.waddr         = r_total[gvc_pkg::EDGE_W-1:0];
                            o_edge_req.wdata.covered = 1'b0;
                            o_edge_req.wdata.first   = gvc_pkg::NODE_W'(i_end_a);
                            o_edge_req.wdata.second  = gvc_pkg::NODE_W'(i_end_b);
                            n_total = r_total + 1'b1;
                            n_uncov = r_uncov + 1'b1;
                            n_state = gvc_pkg::S_RDA;
                        end else begin
                            n_over = 1'b1;
                        end
                    end
                end
            end

            // degree bump, first endpoint
            gvc_pkg::S_RDA: begin
                o_node_req.raddr = r_a;
                n_state          = gvc_pkg::S_WRA;
            end
            gvc_pkg::S_WRA: begin
                o_node_req.we             = 1'b1;
                o_node_req.waddr          = r_a;
                o_node_req.wdata.removed  = i_node_rd.removed;
                o_node_req.wdata.degree   = (i_node_rd.degree == gvc_pkg::DEG_MAX) ?
                                            i_node_rd.degree : i_node_rd.degree + 1'b1;
                n_state                   = gvc_pkg::S_RDB;
            end

            // degree bump, second endpoint
            gvc_pkg::S_RDB: begin
                o_node_req.raddr = r_b;
                n_state          = gvc_pkg::S_WRB;
            end
            gvc_pkg::S_WRB: begin
                o_node_req.we             = 1'b1;
                o_node_req.waddr          = r_b;
                o_node_req.wdata.removed  = i_node_rd.removed;
                o_node_req.wdata.degree   = (i_node_rd.degree == gvc_pkg::DEG_MAX) ?
                                            i_node_rd.degree : i_node_rd.degree + 1'b1;
                n_state = r_last ? gvc_pkg::S_START : gvc_pkg::S_IDLE;
            end

            // next round of the cover or on to the bitmap
            gvc_pkg::S_START: begin
                n_chunk = '0;
                n_bit   = '0;
                n_rd_ok = 1'b0;
                if (r_uncov == '0) begin
                    n_state = gvc_pkg::S_OUT_RD;
                end else begin
                    n_idx   = '0;
                    n_best  = '0;
                    n_found = 1'b0;
                    n_state = gvc_pkg::S_SCAN;
                end
            end

            // max-degree scan, compare uses the word read in the previous cycle
            gvc_pkg::S_SCAN: begin
                o_node_req.raddr = r_idx[gvc_pkg::NODE_W-1:0];
                if ((r_idx != '0) && !i_node_rd.removed && (i_node_rd.degree > r_best)) begin
                    n_best  = i_node_rd.degree;
                    n_pick  = gvc_pkg::NODE_W'(r_idx - 1'b1);
                    n_found = 1'b1;
                end
                if (r_idx == (gvc_pkg::NODE_W + 1)'(gvc_pkg::NODES)) begin
                    n_state = gvc_pkg::S_PICK;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            // remove the picked node, its degree goes to zero at once; if none, on to the bitmap
            gvc_pkg::S_PICK: begin
                if (!r_found) begin
                    n_state = gvc_pkg::S_OUT_RD;
                end else begin
                    o_node_req.we            = 1'b1;
                    o_node_req.waddr         = r_pick;
                    o_node_req.wdata.removed = 1'b1;
                    o_node_req.wdata.degree  = '0;
                    n_count = r_count + 1'b1;
                    n_e     = '0;
                    n_state = gvc_pkg::S_EISSUE;
                end
            end

            // edge sweep
            gvc_pkg::S_EISSUE: begin
                o_edge_req.raddr = r_e[gvc_pkg::EDGE_W-1:0];
                n_state          = gvc_pkg::S_ECHK;
            end
            gvc_pkg::S_ECHK: begin
                if (hit) begin
                    o_edge_req.we            = 1'b1;
                    o_edge_req.waddr         = r_e[gvc_pkg::EDGE_W-1:0];
                    o_edge_req.wdata.covered = 1'b1;
                    o_edge_req.wdata.first   = i_edge_rd.first;
                    o_edge_req.wdata.second  = i_edge_rd.second;
                    n_uncov = r_uncov - 1'b1;
                    n_other = (i_edge_rd.first == r_pick) ? i_edge_rd.second
                                                          : i_edge_rd.first;
                    o_node_req.raddr = n_other;
                    n_state = gvc_pkg::S_DEC;
                end else if (e_done) begin
                    n_state = gvc_pkg::S_START;
                end else begin
                    n_e     = r_e + 1'b1;
                    n_state = gvc_pkg::S_EISSUE;
                end
            end

            // saturating decrement of the other endpoint
            gvc_pkg::S_DEC: begin
                o_node_req.we            = 1'b1;
                o_node_req.waddr         = r_other;
                o_node_req.wdata.removed = i_node_rd.removed;
                o_node_req.wdata.degree  = (i_node_rd.degree != '0) ?
                                           i_node_rd.degree - 1'b1 : i_node_rd.degree;
                if (e_done) begin
                    n_state = gvc_pkg::S_START;
                end else begin
                    n_e     = r_e + 1'b1;
                    n_state = gvc_pkg::S_EISSUE;
                end
            end

            // gather one chunk, clearing each node entry as it is read
            gvc_pkg::S_OUT_RD: begin
                if (span_ok) begin
                    o_node_req.raddr = span[gvc_pkg::NODE_W-1:0];
                    o_node_req.we    = 1'b1;
                    o_node_req.waddr = span[gvc_pkg::NODE_W-1:0];
                end
                n_rd_ok = span_ok;
                if (r_bit != '0) begin
                    n_bits[gvc_pkg::CB_W'(r_bit - 1'b1)] = r_rd_ok & i_node_rd.removed;
                end
                if (r_bit == (gvc_pkg::CB_W + 1)'(gvc_pkg::CHUNK_BITS)) begin
                    o_load       = 1'b1;
                    o_chunk.bits = gvc_pkg::BITS_W'(n_bits);
                    n_state      = gvc_pkg::S_SHOW;
                end else begin
                    n_bit = r_bit + 1'b1;
                end
            end

            // wait for the chunk transaction, then next chunk or done
            gvc_pkg::S_SHOW: begin
                if (i_taken) begin
                    if (chunk_last) begin
                        n_total = '0;
                        n_uncov = '0;
                        n_over  = 1'b0;
                        n_count = '0;
                        n_state = gvc_pkg::S_IDLE;
                    end else begin
                        n_chunk = r_chunk + 1'b1;
                        n_bit   = '0;
                        n_rd_ok = 1'b0;
                        n_state = gvc_pkg::S_OUT_RD;
                    end
                end
            end

            default: begin
                n_state = gvc_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/greedy_vertex_cover_top.sv =====
// ============================================================================
// greedy_vertex_cover_top: greedy max-degree vertex cover
// Stores a streamed edge set, removes max-degree nodes until all edges are
// covered and returns the cover as node bitmap chunks.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  edge in  | input     | i_valid / o_stall  | end_a, end_b, edge_valid,
//           |           |                    | set_last
//  chunk out| output    | o_valid / i_stall  | chunk_index, removed_bits,
//           |           |                    | removed_count, edges_dropped,
//           |           |                    | chunk_last
//
// A stored edge is accepted and then does two read-modify-writes of the
// node store; a dropped edge or empty item needs no node store access.
// Each cover round starts, scans every node and picks one, then sweeps all
// stored edges and decrements the other endpoint of each edge it covers.
// Result: the bitmap leaves one chunk at a time, each held until taken.
// After reset a clearing pass over all NODES entries runs with o_stall high.
// ============================================================================
module greedy_vertex_cover_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [gvc_pkg::END_W-1:0]    i_end_a,
    input  logic [gvc_pkg::END_W-1:0]    i_end_b,
    input  logic                         i_edge_valid,
    input  logic                         i_set_last,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [gvc_pkg::CIDX_W-1:0]   o_chunk_index,
    output logic [gvc_pkg::BITS_W-1:0]   o_removed_bits,
    output logic [gvc_pkg::RCNT_W-1:0]   o_removed_count,
    output logic                         o_edges_dropped,
    output logic                         o_chunk_last
);

    gvc_pkg::t_node_req  node_req;
    gvc_pkg::t_node_word node_rd;
    gvc_pkg::t_edge_req  edge_req;
    gvc_pkg::t_edge_word edge_rd;
    gvc_pkg::t_chunk     chunk;
    gvc_pkg::t_chunk     r_out;
    logic                r_out_valid;
    logic                load;
    logic                taken;

    gvc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_end_a      (i_end_a),
        .i_end_b      (i_end_b),
        .i_edge_valid (i_edge_valid),
        .i_set_last   (i_set_last),
        .o_node_req   (node_req),
        .i_node_rd    (node_rd),
        .o_edge_req   (edge_req),
        .i_edge_rd    (edge_rd),
        .o_load       (load),
        .o_chunk      (chunk),
        .i_taken      (taken)
    );

    gvc_node_mem u_node_mem (
        .i_clk   (i_clk),
        .i_req   (node_req),
        .o_rdata (node_rd)
    );

    gvc_edge_mem u_edge_mem (
        .i_clk   (i_clk),
        .i_req   (edge_req),
        .o_rdata (edge_rd)
    );

    // result transaction completes
    assign taken = r_out_valid & ~i_stall;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (taken) begin
            r_out_valid <= 1'b0;
        end
        if (load) begin
            r_out <= chunk;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_chunk_index   = r_out.index;
    assign o_removed_bits  = r_out.bits;
    assign o_removed_count = r_out.count;
    assign o_edges_dropped = r_out.dropped;
    assign o_chunk_last    = r_out.last;

endmodule

// ===== rtl/gvc_checker.sv =====
// ============================================================================
// gvc_checker: port-level checks for the greedy vertex cover block
// Watches the two channels of the top level, attached by bind.
// ============================================================================
module gvc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         i_set_last,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [gvc_pkg::CIDX_W-1:0]   o_chunk_index,
    input logic [gvc_pkg::BITS_W-1:0]   o_removed_bits,
    input logic [gvc_pkg::RCNT_W-1:0]   o_removed_count,
    input logic                         o_edges_dropped,
    input logic                         o_chunk_last
);

    // no edge transaction is taken while a chunk is pending
    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("edge input open while a chunk is pending");

    // a stalled chunk holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_removed_bits) &&
                                  $stable(o_chunk_index) && $stable(o_removed_count) &&
                                  $stable(o_edges_dropped) && $stable(o_chunk_last)))
        else $error("stalled chunk changed");

    // a closing item starts the cover, input closes the next cycle
    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_set_last) |=> o_stall)
        else $error("input open right after closing item");

    // chunks are gathered one at a time, never back to back
    a_chunk_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |=> !o_valid)
        else $error("chunk shown right after previous transaction");

    // final chunk carries the highest chunk number
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_chunk_last) |->
            (o_chunk_index == gvc_pkg::CIDX_W'(gvc_pkg::CHUNKS - 1)))
        else $error("final chunk has wrong index");

endmodule

bind greedy_vertex_cover_top gvc_checker u_gvc_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking testbench for greedy_vertex_cover_top
// Streams edge sets into the block and predicts each cover in the bench:
// degrees are counted per endpoint, the lowest-numbered node with the
// strictly greatest remaining degree is removed until every edge is covered,
// and the removed-node bitmap is expected as one transaction per chunk.
// Covers empty sets, self-loops, degree ties, chunk boundaries, a store
// overflow set and random sets, with random sender gaps and receiver stalls.
// ============================================================================
module tb;
    import gvc_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RANDOM_ITEMS   = 24;
    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int TAIL_CYCLES    = 300;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_HOLD
    } t_stall_mode;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_valid      = 1'b0;
    logic                o_stall;
    logic [END_W-1:0]    i_end_a      = '0;
    logic [END_W-1:0]    i_end_b      = '0;
    logic                i_edge_valid = 1'b0;
    logic                i_set_last   = 1'b0;
    logic                o_valid;
    logic                i_stall      = 1'b0;
    logic [CIDX_W-1:0]   o_chunk_index;
    logic [BITS_W-1:0]   o_removed_bits;
    logic [RCNT_W-1:0]   o_removed_count;
    logic                o_edges_dropped;
    logic                o_chunk_last;

    // bench copy of the edge set and node degrees
    logic [END_W-1:0]    edge_a_store [MAX_EDGES];
    logic [END_W-1:0]    edge_b_store [MAX_EDGES];
    bit                  edge_done    [MAX_EDGES];
    logic [DEG_W-1:0]    deg_left     [NODES];
    bit                  in_cover     [NODES];
    int                  edges_held;
    int                  edges_open;
    bit                  store_overflow;

    t_chunk              expected_chunks [$];
    t_chunk              want_chunk;

    int                  burst_left     = 0;
    int                  items_sent     = 0;
    int                  sets_closed    = 0;
    int                  edges_dropped_seen = 0;
    int                  chunks_checked = 0;
    int                  mismatches     = 0;
    int                  quiet_cycles   = 0;
    t_stall_mode         stall_mode     = STALL_NONE;
    int                  stall_left     = 0;

    greedy_vertex_cover_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_end_a         (i_end_a),
        .i_end_b         (i_end_b),
        .i_edge_valid    (i_edge_valid),
        .i_set_last      (i_set_last),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_chunk_index   (o_chunk_index),
        .o_removed_bits  (o_removed_bits),
        .o_removed_count (o_removed_count),
        .o_edges_dropped (o_edges_dropped),
        .o_chunk_last    (o_chunk_last)
    );

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // forget the current edge set
    function automatic void clear_edge_set();
        int n;
        int e;
        for (n = 0; n < NODES; n++) begin
            deg_left[n] = '0;
            in_cover[n] = 1'b0;
        end
        for (e = 0; e < MAX_EDGES; e++) begin
            edge_done[e] = 1'b0;
        end
        edges_held     = 0;
        edges_open     = 0;
        store_overflow = 1'b0;
    endfunction

    // store one accepted item; on set_last build the greedy cover and queue its chunks
    function automatic void apply_edge_item(input logic [END_W-1:0] a, b,
                                            input logic ev, last);
        int               pick;
        int               best;
        int               n;
        int               e;
        int               c;
        int               i;
        int               taken;
        bit               found;
        logic [END_W-1:0] other;
        t_chunk           chunk;
        if (ev && int'(a) < NODES && int'(b) < NODES) begin
            if (edges_held < MAX_EDGES) begin
                edge_a_store[edges_held] = a;
                edge_b_store[edges_held] = b;
                edge_done[edges_held]    = 1'b0;
                edges_held++;
                edges_open++;
                if (deg_left[a] < DEG_MAX) deg_left[a]++;
                if (deg_left[b] < DEG_MAX) deg_left[b]++;
            end else begin
                store_overflow = 1'b1;
                edges_dropped_seen++;
            end
        end
        if (!last) return;

        // remove max-degree nodes until every stored edge is covered
        found = 1'b1;
        while (edges_open > 0 && found) begin
            found = 1'b0;
            best  = 0;
            pick  = 0;
            for (n = 0; n < NODES; n++) begin
                if (!in_cover[n] && int'(deg_left[n]) > best) begin
                    best  = deg_left[n];
                    pick  = n;
                    found = 1'b1;
                end
            end
            if (found) begin
                in_cover[pick] = 1'b1;
                for (e = 0; e < edges_held; e++) begin
                    if (!edge_done[e] && (edge_a_store[e] == pick || edge_b_store[e] == pick))
                    begin
                        other = (edge_a_store[e] == pick) ? edge_b_store[e] : edge_a_store[e];
                        edge_done[e] = 1'b1;
                        edges_open--;
                        if (deg_left[other] > 0) deg_left[other]--;
                    end
                end
                deg_left[pick] = '0;
            end
        end

        // bitmap chunks
        taken = 0;
        for (n = 0; n < NODES; n++) taken += in_cover[n];
        for (c = 0; c < CHUNKS; c++) begin
            chunk.bits = '0;
            for (i = 0; i < CHUNK_BITS; i++) begin
                if (c * CHUNK_BITS + i < NODES && in_cover[c * CHUNK_BITS + i])
                    chunk.bits[i] = 1'b1;
            end
            chunk.index   = CIDX_W'(c);
            chunk.count   = RCNT_W'(taken);
            chunk.dropped = store_overflow;
            chunk.last    = (c == CHUNKS - 1);
            expected_chunks.push_back(chunk);
        end
        sets_closed++;
        clear_edge_set();
    endfunction

    // drive one item, with a random gap when the current burst is used up
    task automatic send_item(input logic [END_W-1:0] a, b, input logic ev, last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) begin
                i_end_a      <= END_W'($urandom);
                i_end_b      <= END_W'($urandom);
                i_edge_valid <= 1'($urandom);
                i_set_last   <= 1'($urandom);
                @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        i_end_a      <= a;
        i_end_b      <= b;
        i_edge_valid <= ev;
        i_set_last   <= last;
        i_valid      <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        apply_edge_item(a, b, ev, last);
        if (ev || last) items_sent++;
        @(negedge i_clk);
    endtask

    // hold the sender off until every queued chunk has arrived
    task automatic wait_for_results();
        i_valid   <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (expected_chunks.size() != 0) @(negedge i_clk);
    endtask

    // closing item with no edge on an empty set
    task automatic test_empty_set();
        send_item(8'hA5, 8'h5A, 1'b0, 1'b1);
    endtask

    // one edge between the extreme nodes, then a self-loop, each closing its own set
    task automatic test_single_edges();
        send_item(8'h00, 8'hFF, 1'b1, 1'b1);
        send_item(8'hFF, 8'hFF, 1'b1, 1'b1);
    endtask

    // star around one hub, an empty item inside the set, and an empty closing item
    task automatic test_star();
        send_item(8'd5, 8'd9, 1'b1, 1'b0);
        send_item(8'd9, 8'd200, 1'b1, 1'b0);
        send_item(8'd31, 8'd9, 1'b1, 1'b0);
        send_item(8'hFF, 8'h00, 1'b0, 1'b0);
        send_item(8'd32, 8'd9, 1'b1, 1'b0);
        send_item(8'd200, 8'd201, 1'b1, 1'b1);
        send_item(8'd100, 8'd150, 1'b1, 1'b0);
        send_item(8'd0, 8'd0, 1'b0, 1'b1);
    endtask

    // equal degrees pick the lowest node; paths that cross chunk boundaries
    task automatic test_ties();
        send_item(8'd10, 8'd11, 1'b1, 1'b0);
        send_item(8'd11, 8'd12, 1'b1, 1'b0);
        send_item(8'd12, 8'd10, 1'b1, 1'b1);
        send_item(8'd31, 8'd32, 1'b1, 1'b0);
        send_item(8'd32, 8'd33, 1'b1, 1'b0);
        send_item(8'd63, 8'd64, 1'b1, 1'b0);
        send_item(8'd64, 8'd95, 1'b1, 1'b1);
    endtask

    // self-loops count twice and decrement their own node when covered
    task automatic test_self_loops();
        send_item(8'd7, 8'd7, 1'b1, 1'b0);
        send_item(8'd7, 8'd8, 1'b1, 1'b0);
        send_item(8'd8, 8'd8, 1'b1, 1'b1);
    endtask

    // fill the edge store with a doubled matching, then push edges past capacity
    task automatic test_store_full();
        int i;
        for (i = 0; i < MAX_EDGES / 2; i++)
            send_item(END_W'(i), END_W'(i + NODES / 2), 1'b1, 1'b0);
        for (i = 0; i < MAX_EDGES / 2; i++)
            send_item(END_W'(i + NODES / 2), END_W'(i), 1'b1, 1'b0);
        repeat (7) send_item(END_W'($urandom), END_W'($urandom), 1'b1, 1'b0);
        send_item(END_W'($urandom), END_W'($urandom), 1'b1, 1'b1);
    endtask

    // random sets of mostly small size over node windows of varying width
    task automatic test_random_sets();
        int               stop_at;
        int               set_no;
        int               set_edges;
        int               base;
        int               span;
        int               k;
        logic [END_W-1:0] a;
        logic [END_W-1:0] b;
        logic             ev;
        stop_at = items_sent + RANDOM_ITEMS;
        set_no  = 0;
        while (items_sent < stop_at) begin
            set_edges = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                    : $urandom_range(0, 12);
            base = $urandom_range(0, NODES - 1);
            case ($urandom_range(0, 3))
                0: span = 3;
                1: span = 15;
                2: span = 63;
                default: span = 255;
            endcase
            for (k = 0; k <= set_edges; k++) begin
                a  = END_W'(base + $urandom_range(0, span));
                b  = END_W'(base + $urandom_range(0, span));
                if ($urandom_range(0, 7) == 0) b = a;
                ev = ($urandom_range(0, 9) != 0);
                send_item(a, b, ev, k == set_edges);
            end
            if (set_no == 0 || $urandom_range(0, 7) == 0) wait_for_results();
            set_no++;
        end
    endtask

    // receiver stall pattern: free runs, random stalls and solid holds
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 2));
            stall_left <= $urandom_range(8, 60);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:   i_stall <= 1'b0;
            STALL_RANDOM: i_stall <= 1'($urandom);
            default:      i_stall <= (stall_left < 12);
        endcase
    end

    // compare one field of a result transaction
    function automatic void check_field(input string field, input logic [31:0] want, got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_chunks.size() == 0) begin
                $error("unexpected chunk transaction: chunk_index %0d", o_chunk_index);
                mismatches++;
            end else begin
                want_chunk = expected_chunks.pop_front();
                check_field("chunk_index", 32'(want_chunk.index), 32'(o_chunk_index));
                check_field("removed_bits", want_chunk.bits, o_removed_bits);
                check_field("removed_count", 32'(want_chunk.count), 32'(o_removed_count));
                check_field("edges_dropped", 32'(want_chunk.dropped), 32'(o_edges_dropped));
                check_field("chunk_last", 32'(want_chunk.last), 32'(o_chunk_last));
                chunks_checked++;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: FAIL");
            $finish;
        end
    end

    // test sequence
    initial begin
        clear_edge_set();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_set();
        test_single_edges();
        test_star();
        test_ties();
        test_self_loops();
        test_store_full();
        test_random_sets();

        wait_for_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("summary: %0d edge sets closed from %0d items, %0d edges past store capacity",
                 sets_closed, items_sent, edges_dropped_seen);
        $display("summary: %0d chunk transactions checked, %0d mismatches",
                 chunks_checked, mismatches);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
